// ===== hdl/efaa_pkg.sv =====
// types, constants and microcode rom of the exact-fit arena allocator
// stands alone; used by exact_fit_arena_allocator

package efaa_pkg;

   localparam int BYTES_W  = 16;
   localparam int OFFSET_W = 12;
   localparam int STEP_W   = 4;

   typedef enum logic [0:0] {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTES_W-1:0]    request_bytes;
      logic [OFFSET_W-1:0]   release_offset;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]   granted_offset;
      status_type            status;
   } rsp_type;

   // program counter values
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_EMIT        = 4'd0;
   localparam step_type STEP_IDLE        = 4'd1;
   localparam step_type STEP_DISPATCH    = 4'd2;
   localparam step_type STEP_NEED        = 4'd3;
   localparam step_type STEP_WALK_TEST   = 4'd4;
   localparam step_type STEP_WALK_MATCH  = 4'd5;
   localparam step_type STEP_WALK_STEP   = 4'd6;
   localparam step_type STEP_CARVE       = 4'd7;
   localparam step_type STEP_CARVE_WRITE = 4'd8;
   localparam step_type STEP_HIT         = 4'd9;
   localparam step_type STEP_NOSPACE     = 4'd10;
   localparam step_type STEP_FREE_CHECK  = 4'd11;
   localparam step_type STEP_FREE_WRITE  = 4'd12;
   localparam step_type STEP_BADFREE     = 4'd13;

   typedef enum logic [3:0] {
      COND_ALWAYS    = 4'd0,
      COND_NO_REQ    = 4'd1,
      COND_KIND_FREE = 4'd2,
      COND_WALK_END  = 4'd3,
      COND_FIT       = 4'd4,
      COND_SIZE_NZ   = 4'd5,
      COND_NO_ROOM   = 4'd6,
      COND_BAD_FREE  = 4'd7,
      COND_OUT_BUSY  = 4'd8
   } cond_type;

   typedef enum logic [1:0] {
      ADDR_WALK = 2'd0,
      ADDR_BUMP = 2'd1,
      ADDR_FREE = 2'd2
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_CARVE      = 2'd0,
      WD_CLEAR_MARK = 2'd1,
      WD_SET_MARK   = 2'd2
   } wdata_sel_type;

   typedef enum logic [1:0] {
      WALK_HOLD    = 2'd0,
      WALK_ZERO    = 2'd1,
      WALK_ADVANCE = 2'd2
   } walk_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_BUMP = 2'd1,
      RES_WALK = 2'd2
   } res_sel_type;

   typedef struct packed {
      logic          take_req;
      cond_type      cond;
      step_type      target;
      logic          rd_en;
      logic          wr_en;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      walk_sel_type  walk_sel;
      logic          ld_prod;
      logic          ld_need;
      logic          bump_adv;
      logic          ld_result;
      res_sel_type   res_sel;
      status_type    status;
      logic          emit;
   } ctl_word_type;

   function automatic ctl_word_type ctl_rom(step_type step);
      ctl_word_type w;
      w = '0;
      w.cond      = COND_ALWAYS;
      w.target    = STEP_IDLE;
      w.addr_sel  = ADDR_WALK;
      w.wdata_sel = WD_CARVE;
      w.walk_sel  = WALK_HOLD;
      w.res_sel   = RES_ZERO;
      w.status    = STATUS_OK;
      unique case (step)
         STEP_EMIT: begin
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_EMIT;
            w.emit   = 1'b1;
         end
         STEP_IDLE: begin
            w.take_req = 1'b1;
            w.cond     = COND_NO_REQ;
            w.target   = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.cond     = COND_KIND_FREE;
            w.target   = STEP_FREE_CHECK;
            w.ld_prod  = 1'b1;
            w.walk_sel = WALK_ZERO;
         end
         STEP_NEED: begin
            w.target  = STEP_WALK_TEST;
            w.ld_need = 1'b1;
         end
         STEP_WALK_TEST: begin
            w.cond     = COND_WALK_END;
            w.target   = STEP_CARVE;
            w.rd_en    = 1'b1;
            w.addr_sel = ADDR_WALK;
         end
         STEP_WALK_MATCH: begin
            w.cond   = COND_FIT;
            w.target = STEP_HIT;
         end
         STEP_WALK_STEP: begin
            w.cond     = COND_SIZE_NZ;
            w.target   = STEP_WALK_TEST;
            w.walk_sel = WALK_ADVANCE;
         end
         STEP_CARVE: begin
            w.cond   = COND_NO_ROOM;
            w.target = STEP_NOSPACE;
         end
         STEP_CARVE_WRITE: begin
            w.target    = STEP_EMIT;
            w.wr_en     = 1'b1;
            w.addr_sel  = ADDR_BUMP;
            w.wdata_sel = WD_CARVE;
            w.bump_adv  = 1'b1;
            w.ld_result = 1'b1;
            w.res_sel   = RES_BUMP;
            w.status    = STATUS_OK;
         end
         STEP_HIT: begin
            w.target    = STEP_EMIT;
            w.wr_en     = 1'b1;
            w.addr_sel  = ADDR_WALK;
            w.wdata_sel = WD_CLEAR_MARK;
            w.ld_result = 1'b1;
            w.res_sel   = RES_WALK;
            w.status    = STATUS_OK;
         end
         STEP_NOSPACE: begin
            w.target    = STEP_EMIT;
            w.ld_result = 1'b1;
            w.res_sel   = RES_ZERO;
            w.status    = STATUS_NO_SPACE;
         end
         STEP_FREE_CHECK: begin
            w.cond     = COND_BAD_FREE;
            w.target   = STEP_BADFREE;
            w.rd_en    = 1'b1;
            w.addr_sel = ADDR_FREE;
         end
         STEP_FREE_WRITE: begin
            w.target    = STEP_EMIT;
            w.wr_en     = 1'b1;
            w.addr_sel  = ADDR_FREE;
            w.wdata_sel = WD_SET_MARK;
            w.ld_result = 1'b1;
            w.res_sel   = RES_ZERO;
            w.status    = STATUS_OK;
         end
         STEP_BADFREE: begin
            w.target    = STEP_EMIT;
            w.ld_result = 1'b1;
            w.res_sel   = RES_ZERO;
            w.status    = STATUS_BAD_FREE;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/exact_fit_arena_allocator.sv =====
// exact-fit arena allocator: microcoded sequencer, header memory and datapath
// depends on efaa_pkg (types, constants, microcode rom)

// Allocates and frees variable-sized blocks in a word arena of ARENA_WORDS words.
// Each block starts with HEADER_WORDS header words; the header memory keeps the
// block size and a free mark at each block's start word. An allocate request
// rounds request_bytes up to whole words, adds the header and walks the chain of
// blocks from word 0 up to the bump pointer, reusing the first free block of
// exactly that size; failing that it carves a new block at the bump pointer or
// answers out of space. A free request checks the payload offset and sets the
// free mark of that block. One request is worked at a time; the response sits in
// an output register so the next request can be taken while it waits. The
// walk spends a test, a match and an advance step on each header, since the
// single-port header memory has a registered read. No clearing pass after
// reset: headers are read only after they were written.

module exact_fit_arena_allocator #(
   parameter int ARENA_WORDS    = 4096,
   parameter int BYTES_PER_WORD = 4,
   parameter int HEADER_WORDS   = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  efaa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output efaa_pkg::rsp_type rsp_data
);

   // pointer and size width: must hold ARENA_WORDS itself
   localparam int PTR_W   = $clog2(ARENA_WORDS + 1);
   localparam int IDX_W   = $clog2(ARENA_WORDS);
   localparam int ENTRY_W = PTR_W + 1;
   // walk pointer gets one spare bit so pointer plus size never wraps
   localparam int WALK_W  = PTR_W + 1;
   // rounded byte count and block need in words
   localparam int ROUND_W = efaa_pkg::BYTES_W + 1;
   localparam int NEED_W  = ROUND_W;
   // common width for compares
   localparam int CMP_W   = ((NEED_W > WALK_W) ? NEED_W : WALK_W) + 1;
   // divide by word size as multiply by reciprocal, exact for ROUND_W-bit values
   localparam int DIV_SHIFT = ROUND_W + 3;
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam int PROD_W    = ROUND_W + MULT_W;
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'(((1 << DIV_SHIFT) + BYTES_PER_WORD - 1) / BYTES_PER_WORD);

   // sequencer
   efaa_pkg::step_type     upc_ff, upc_in;
   efaa_pkg::ctl_word_type ctl;
   logic                   cond_hit;

   // request latch
   efaa_pkg::req_type      req_ff;

   // datapath
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [WALK_W-1:0]      walk_ff, walk_in;
   logic [PTR_W-1:0]       bump_ff, bump_in;
   logic [ROUND_W-1:0]     round_sum;
   logic [ROUND_W-1:0]     quotient;

   // header memory
   logic [ENTRY_W-1:0]     hdr_mem [ARENA_WORDS];
   logic [ENTRY_W-1:0]     rd_ff;
   logic [IDX_W-1:0]       mem_addr;
   logic [ENTRY_W-1:0]     mem_wdata;
   logic [PTR_W-1:0]       rd_size;
   logic                   rd_free;
   logic [IDX_W-1:0]       free_addr;

   // result holding and output register
   logic [efaa_pkg::OFFSET_W-1:0] res_off_ff, res_off_in;
   efaa_pkg::status_type          res_status_ff;
   logic                          rsp_valid_ff;
   efaa_pkg::rsp_type             rsp_data_ff;

   // conditions
   logic out_busy;
   logic walk_end;
   logic fit;
   logic no_room;
   logic bad_free;
   logic [CMP_W-1:0] off_cmp;

   // control word of the current step
   assign ctl = efaa_pkg::ctl_rom(upc_ff);

   assign req_ready = ctl.take_req;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_size = rd_ff[PTR_W:1];
   assign rd_free = rd_ff[0];
   assign off_cmp = CMP_W'(req_ff.release_offset);

   // payload word offset minus header gives the block start
   assign free_addr = IDX_W'(off_cmp - CMP_W'(HEADER_WORDS));

   assign out_busy = rsp_valid_ff && !rsp_ready;
   // bump pointer never passes the arena end, so this also bounds the walk
   assign walk_end = CMP_W'(walk_ff) >= CMP_W'(bump_ff);
   assign fit      = rd_free && (CMP_W'(rd_size) == CMP_W'(need_ff));
   assign no_room  = (CMP_W'(ARENA_WORDS) - CMP_W'(bump_ff)) < CMP_W'(need_ff);
   // offset below header, at or past the bump pointer, or block past arena end
   assign bad_free = (off_cmp < CMP_W'(HEADER_WORDS)) ||
                     (off_cmp >= CMP_W'(bump_ff)) ||
                     ((off_cmp - CMP_W'(HEADER_WORDS)) >= CMP_W'(ARENA_WORDS));

   // jump condition select
   always_comb begin
      unique case (ctl.cond)
         efaa_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         efaa_pkg::COND_NO_REQ:    cond_hit = !req_valid;
         efaa_pkg::COND_KIND_FREE: cond_hit = (req_ff.kind == efaa_pkg::KIND_FREE);
         efaa_pkg::COND_WALK_END:  cond_hit = walk_end;
         efaa_pkg::COND_FIT:       cond_hit = fit;
         efaa_pkg::COND_SIZE_NZ:   cond_hit = (rd_size != '0);
         efaa_pkg::COND_NO_ROOM:   cond_hit = no_room;
         efaa_pkg::COND_BAD_FREE:  cond_hit = bad_free;
         efaa_pkg::COND_OUT_BUSY:  cond_hit = out_busy;
         default:                  cond_hit = 1'b0;
      endcase
   end

   // next step: taken jump or fall through
   assign upc_in = cond_hit ? ctl.target : efaa_pkg::step_type'(upc_ff + 1'b1);

   // words needed = ceil(bytes / word size) + header
   assign round_sum = ROUND_W'(req_ff.request_bytes) + ROUND_W'(BYTES_PER_WORD - 1);
   assign prod_in   = PROD_W'(round_sum) * PROD_W'(DIV_MULT);
   assign quotient  = prod_ff[DIV_SHIFT +: ROUND_W];
   assign need_in   = NEED_W'(quotient) + NEED_W'(HEADER_WORDS);

   // walk pointer
   always_comb begin
      unique case (ctl.walk_sel)
         efaa_pkg::WALK_HOLD:    walk_in = walk_ff;
         efaa_pkg::WALK_ZERO:    walk_in = '0;
         efaa_pkg::WALK_ADVANCE: walk_in = walk_ff + WALK_W'(rd_size);
         default:                walk_in = walk_ff;
      endcase
   end

   // bump pointer advances by the carved size; sum stays within the arena
   assign bump_in = ctl.bump_adv ? PTR_W'(CMP_W'(bump_ff) + CMP_W'(need_ff)) : bump_ff;

   // header memory address and write data
   always_comb begin
      unique case (ctl.addr_sel)
         efaa_pkg::ADDR_WALK: mem_addr = IDX_W'(walk_ff);
         efaa_pkg::ADDR_BUMP: mem_addr = IDX_W'(bump_ff);
         efaa_pkg::ADDR_FREE: mem_addr = free_addr;
         default:             mem_addr = IDX_W'(walk_ff);
      endcase
   end

   always_comb begin
      unique case (ctl.wdata_sel)
         efaa_pkg::WD_CARVE:      mem_wdata = {PTR_W'(need_ff), 1'b0};
         efaa_pkg::WD_CLEAR_MARK: mem_wdata = {rd_size, 1'b0};
         efaa_pkg::WD_SET_MARK:   mem_wdata = {rd_size, 1'b1};
         default:                 mem_wdata = {rd_size, 1'b0};
      endcase
   end

   // granted payload offset
   always_comb begin
      unique case (ctl.res_sel)
         efaa_pkg::RES_ZERO: res_off_in = '0;
         efaa_pkg::RES_BUMP:
            res_off_in = efaa_pkg::OFFSET_W'(CMP_W'(bump_ff) + CMP_W'(HEADER_WORDS));
         efaa_pkg::RES_WALK:
            res_off_in = efaa_pkg::OFFSET_W'(CMP_W'(walk_ff) + CMP_W'(HEADER_WORDS));
         default:            res_off_in = '0;
      endcase
   end

   // header memory, single port, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         hdr_mem[mem_addr] <= mem_wdata;
      end
      if (ctl.rd_en) begin
         rd_ff <= hdr_mem[mem_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= efaa_pkg::STEP_IDLE;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         bump_ff <= bump_in;
         if (ctl.emit && !out_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.take_req && req_valid) begin
         req_ff <= req_data;
      end
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld_need) begin
         need_ff <= need_in;
      end
      walk_ff <= walk_in;
      if (ctl.ld_result) begin
         res_off_ff    <= res_off_in;
         res_status_ff <= ctl.status;
      end
      if (ctl.emit && !out_busy) begin
         rsp_data_ff.granted_offset <= res_off_ff;
         rsp_data_ff.status         <= res_status_ff;
      end
   end

endmodule
